// ===== rtl/sorted_key_table_binary_search_assert.svh =====
// assertion macros for the sorted key table
`ifndef SORTED_KEY_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_KEY_TABLE_BINARY_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

`define SKTBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sktbs assertion failed");

`define SKTBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sktbs assertion failed");

`else

`define SKTBS_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define SKTBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/sktbs_pkg.sv =====
`default_nettype none

package sktbs_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_PLACE,
        ST_SHIFT,
        ST_DRAIN,
        ST_WRITE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic drop;
        logic place_lo;
        logic search_rd;
        logic search_cmp;
        logic shift_start;
        logic shift_step;
        logic write_new;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic op_ins;
        logic full;
        logic range_empty;
        logic key_eq;
        logic shift_need;
        logic shift_last;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/sktbs_ctrl.sv =====
`default_nettype none

module sktbs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sktbs_pkg::status_t st,
    output sktbs_pkg::cmd_t    cmd
);
    import sktbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:
            begin
                if (st.op_ins && st.full)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (st.range_empty)
                begin
                    // search ended without a match, insert point is low
                    cmd.place_lo = 1'b1;
                    state_next   = st.op_ins ? ST_PLACE : ST_RESULT;
                end
                else
                begin
                    cmd.search_rd = 1'b1;
                    state_next    = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP:
            begin
                cmd.search_cmp = 1'b1;
                if (st.key_eq)
                begin
                    state_next = st.op_ins ? ST_PLACE : ST_RESULT;
                end
                else
                begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_PLACE:
            begin
                if (st.shift_need)
                begin
                    cmd.shift_start = 1'b1;
                    state_next      = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (st.shift_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last moved entry is written this cycle
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.write_new = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!st.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sktbs_dp.sv =====
`default_nettype none

module sktbs_dp
#(
    parameter int CAPACITY = 256
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 operation,
    input  logic signed [sktbs_pkg::KEY_W-1:0]   key,
    input  logic        [sktbs_pkg::VAL_W-1:0]   value_in,
    input  sktbs_pkg::cmd_t                      cmd,
    output sktbs_pkg::status_t                   st,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit,
    output logic        [sktbs_pkg::VAL_W-1:0]   value_out,
    output logic                                 full_drop
);
    import sktbs_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [KEY_W-1:0] key_mem [CAPACITY];
    logic        [VAL_W-1:0] val_mem [CAPACITY];

    logic                    op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic        [VAL_W-1:0] val_reg;
    logic        [CW-1:0]    count_reg;
    logic        [CW-1:0]    lo_reg;
    logic        [CW-1:0]    hi_reg;
    logic        [CW-1:0]    pos_reg;
    logic        [AW-1:0]    mid_reg;
    logic        [AW-1:0]    sh_reg;
    logic                    pend_reg;
    logic        [AW-1:0]    pend_addr_reg;
    logic signed [KEY_W-1:0] rd_key_reg;
    logic        [VAL_W-1:0] rd_val_reg;
    logic                    res_hit_reg;
    logic        [VAL_W-1:0] res_val_reg;
    logic                    res_drop_reg;
    logic                    out_valid_reg;
    logic                    hit_reg;
    logic        [VAL_W-1:0] value_out_reg;
    logic                    full_drop_reg;

    logic        [CW:0]      mid_sum;
    logic        [AW-1:0]    mid;
    logic        [CW-1:0]    mid_ext;
    logic                    rd_en;
    logic        [AW-1:0]    rd_addr;
    logic                    wr_en;
    logic        [AW-1:0]    wr_addr;
    logic signed [KEY_W-1:0] wr_key;
    logic        [VAL_W-1:0] wr_val;
    logic        [CW-1:0]    count_m1;

    // floor((low + high) / 2) with high = hi - 1
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, 1'b1};
    assign mid      = mid_sum[AW:1];
    assign mid_ext  = CW'(mid_reg);
    assign count_m1 = count_reg - {{(CW-1){1'b0}}, 1'b1};

    assign rd_en   = cmd.search_rd | cmd.shift_step;
    assign rd_addr = cmd.search_rd ? mid : sh_reg;
    assign wr_en   = pend_reg | cmd.write_new;
    assign wr_addr = cmd.write_new ? pos_reg[AW-1:0] : pend_addr_reg;
    assign wr_key  = cmd.write_new ? key_reg : rd_key_reg;
    assign wr_val  = cmd.write_new ? val_reg : rd_val_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a read issued while shifting is written one place up next cycle
            pend_reg <= cmd.shift_step;
            if (cmd.write_new)
            begin
                count_reg <= count_reg + {{(CW-1){1'b0}}, 1'b1};
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= operation;
            key_reg      <= key;
            val_reg      <= value_in;
            lo_reg       <= '0;
            hi_reg       <= count_reg;
            res_hit_reg  <= 1'b0;
            res_val_reg  <= '0;
            res_drop_reg <= 1'b0;
        end
        if (cmd.drop)
        begin
            res_drop_reg <= 1'b1;
        end
        if (cmd.place_lo)
        begin
            pos_reg <= lo_reg;
        end
        if (cmd.search_rd)
        begin
            mid_reg <= mid;
        end
        if (cmd.search_cmp)
        begin
            if (rd_key_reg == key_reg)
            begin
                pos_reg <= mid_ext;
                if (!op_reg)
                begin
                    res_hit_reg <= 1'b1;
                    res_val_reg <= rd_val_reg;
                end
            end
            else if (rd_key_reg < key_reg)
            begin
                lo_reg <= mid_ext + {{(CW-1){1'b0}}, 1'b1};
            end
            else
            begin
                hi_reg <= mid_ext;
            end
        end
        if (cmd.shift_start)
        begin
            sh_reg <= count_m1[AW-1:0];
        end
        if (cmd.shift_step)
        begin
            sh_reg        <= sh_reg - {{(AW-1){1'b0}}, 1'b1};
            pend_addr_reg <= sh_reg + {{(AW-1){1'b0}}, 1'b1};
        end
        if (cmd.emit)
        begin
            hit_reg       <= res_hit_reg;
            value_out_reg <= res_val_reg;
            full_drop_reg <= res_drop_reg;
        end
    end

    assign st.op_ins      = op_reg;
    assign st.full        = (count_reg == CW'(CAPACITY));
    assign st.range_empty = (lo_reg >= hi_reg);
    assign st.key_eq      = (rd_key_reg == key_reg);
    assign st.shift_need  = (count_reg > pos_reg);
    assign st.shift_last  = (sh_reg == pos_reg[AW-1:0]);
    assign st.out_busy    = out_valid_reg & out_stall;

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign value_out = value_out_reg;
    assign full_drop = full_drop_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_key_table_binary_search.sv =====
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------
// in       | in_valid / in_stall    | operation, key, value_in
// out      | out_valid / out_stall  | hit, value_out, full_drop
//
// one item at a time; in_stall stays high from the transfer until the result
// is loaded into the output register, and the next transfer can come in the cycle after
// each search probe passes a read state and a compare state over the registered
// read port; an insert then moves each entry at or above the insert point up one
// place, top entry first, and then writes the new entry and counts it;
// reset clears count and control only
// a new item is taken while the previous result waits on out_stall
`default_nettype none
`include "sorted_key_table_binary_search_assert.svh"

module sorted_key_table_binary_search
#(
    parameter int CAPACITY = 256
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic signed [sktbs_pkg::KEY_W-1:0]   key,
    input  logic        [sktbs_pkg::VAL_W-1:0]   value_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit,
    output logic        [sktbs_pkg::VAL_W-1:0]   value_out,
    output logic                                 full_drop
);
    import sktbs_pkg::*;

    cmd_t    cmd;
    status_t st;

    sktbs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    sktbs_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (operation),
        .key       (key),
        .value_in  (value_in),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .value_out (value_out),
        .full_drop (full_drop)
    );

    `SKTBS_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall)
    `SKTBS_ASSERT_NOW(a_hit_or_drop, clk, rst_n, out_valid, !(hit && full_drop))
    `SKTBS_ASSERT_NOW(a_no_write_when_full, clk, rst_n, cmd.write_new, !st.full)
    `SKTBS_ASSERT_NEXT(a_shift_ends, clk, rst_n, cmd.shift_step && st.shift_last, !cmd.shift_step)

endmodule

`default_nettype wire
